>>> hw/rtl/pcst_pkg.sv
// ----------------------------------------------------------------------------
// pcst_pkg
// Shared types and constants of the parent-to-child/sibling table block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcst_pkg;

  // Default table capacity.
  localparam int unsigned MaxNodesDef = 64;

  // Width of a node index on the ports; parents can only name this span.
  localparam int unsigned NodeW   = 6;
  localparam int unsigned ParSpan = 2 ** NodeW;

  // Parent code that marks the root.
  localparam logic [NodeW:0] ParentRoot = 7'h7F;

  typedef enum logic [1:0] {
    KindClear  = 2'd0,
    KindLoad   = 2'd1,
    KindQuery  = 2'd2,
    KindUnused = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StRange = 2'd2
  } status_e;

  typedef enum logic {
    StIdle   = 1'b0,
    StFinish = 1'b1
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic capture;  // latch the input beat and issue the table reads
    logic finish;   // apply the updates and load the result register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic nop;       // incoming beat has the unused kind
    logic out_busy;  // result register full and not taken this cycle
  } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/pcst_if.sv
// ----------------------------------------------------------------------------
// pcst_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcst_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic signed [6:0] parent;
  logic [5:0]        node;

  modport source (output valid, output kind, output parent, output node, input ready);
  modport sink   (input valid, input kind, input parent, input node, output ready);
endinterface

interface pcst_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] father;
  logic       has_father;
  logic [5:0] first_child;
  logic       has_first_child;
  logic [5:0] next_sibling;
  logic       has_next_sibling;
  logic [5:0] root_node;
  logic       has_root;
  logic [6:0] node_count;

  modport source (
    output valid, output status, output father, output has_father,
    output first_child, output has_first_child, output next_sibling,
    output has_next_sibling, output root_node, output has_root, output node_count,
    input ready
  );
  modport sink (
    input valid, input status, input father, input has_father,
    input first_child, input has_first_child, input next_sibling,
    input has_next_sibling, input root_node, input has_root, input node_count,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/pcst_ctrl.sv
// ----------------------------------------------------------------------------
// pcst_ctrl
// Two-state sequencer: capture a beat, then finish it once the result
// register can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module pcst_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pcst_pkg::sts_t sts_i,
  output pcst_pkg::cmd_t cmd_o
);

  pcst_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcst_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.finish  = 1'b0;
    unique case (state_q)
      pcst_pkg::StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        // drop the unused kind right here
        if (in_valid_i && !sts_i.nop) begin
          state_d = pcst_pkg::StFinish;
        end
      end
      pcst_pkg::StFinish: begin
        // hold until the result register frees up
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = pcst_pkg::StIdle;
        end
      end
      default: begin
        state_d = pcst_pkg::StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/pcst_dp.sv
// ----------------------------------------------------------------------------
// pcst_dp
// Tables, counters and result register of the tree builder.
// ----------------------------------------------------------------------------
`default_nettype none

module pcst_dp #(
  parameter int unsigned MAX_NODES = pcst_pkg::MaxNodesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pcst_pkg::cmd_t    cmd_i,
  output pcst_pkg::sts_t    sts_o,
  input  logic [1:0]        kind_i,
  input  logic signed [6:0] parent_i,
  input  logic [5:0]        node_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [1:0]        status_o,
  output logic [5:0]        father_o,
  output logic              has_father_o,
  output logic [5:0]        first_child_o,
  output logic              has_first_child_o,
  output logic [5:0]        next_sibling_o,
  output logic              has_next_sibling_o,
  output logic [5:0]        root_node_o,
  output logic              has_root_o,
  output logic [6:0]        node_count_o
);

  localparam int unsigned IdxW     = $clog2(MAX_NODES);
  localparam int unsigned CntW     = $clog2(MAX_NODES + 1);
  localparam int unsigned ParDepth =
      (MAX_NODES < pcst_pkg::ParSpan) ? MAX_NODES : pcst_pkg::ParSpan;
  localparam int unsigned ParW     = $clog2(ParDepth);

  // Beat captured for the finish cycle.
  pcst_pkg::kind_e kind_q;
  logic [6:0]      parent_q;
  logic [5:0]      node_q;

  // Control state.
  logic [CntW-1:0]     count_q, count_d;
  logic [5:0]          root_idx_q, root_idx_d;
  logic                root_valid_q, root_valid_d;
  logic [ParDepth-1:0] child_valid_q, child_valid_d;

  // Tables: {valid, father}, {valid, sibling}, {first child, last child}.
  logic [6:0]        father_mem [MAX_NODES];
  logic [IdxW:0]     sib_mem    [MAX_NODES];
  logic [2*IdxW-1:0] child_mem  [ParDepth];

  logic [6:0]        father_rd_q;
  logic [IdxW:0]     sib_rd_q;
  logic [2*IdxW-1:0] child_rd_q;

  // Result register.
  logic       out_valid_q;
  logic [1:0] status_q;
  logic [5:0] father_q, first_child_q, next_sibling_q, root_node_q;
  logic       has_father_q, has_first_child_q, has_next_sibling_q, has_root_q;
  logic [6:0] node_count_q;

  logic [IdxW-1:0] cur_idx;
  logic            full;
  logic [31:0]     node_ext;
  logic [IdxW-1:0] node_rd_idx;
  logic [ParW-1:0] child_rd_idx;
  logic            load_cap;

  logic            in_range;
  logic            is_root;
  logic [ParW-1:0] par_idx;
  logic            has_child;
  logic [IdxW-1:0] last_idx;
  logic [IdxW-1:0] first_idx;
  logic            do_load;
  logic            link;

  logic            sib_we;
  logic [IdxW-1:0] sib_wa;
  logic [IdxW:0]   sib_wd;

  logic            k_ok;
  logic [31:0]     cur_ext, first_ext, sib_ext, cnt_ext;
  logic [1:0]      status_d;
  logic [5:0]      father_d, first_child_d, next_sibling_d;
  logic            has_father_d, has_first_child_d, has_next_sibling_d;

  // --- capture side --------------------------------------------------------
  assign cur_idx      = count_q[IdxW-1:0];
  assign full         = (32'(count_q) == MAX_NODES);
  assign node_ext     = 32'(node_i);
  assign node_rd_idx  = node_ext[IdxW-1:0];
  assign child_rd_idx = (kind_i == pcst_pkg::KindQuery) ? node_i[ParW-1:0]
                                                        : parent_i[ParW-1:0];
  assign load_cap     = cmd_i.capture && (kind_i == pcst_pkg::KindLoad) && !full;

  assign sts_o.nop      = (kind_i == pcst_pkg::KindUnused);
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q   <= pcst_pkg::kind_e'(kind_i);
      parent_q <= parent_i;
      node_q   <= node_i;
    end
  end

  // --- finish side ---------------------------------------------------------
  assign in_range  = !parent_q[6] && (32'(parent_q[5:0]) < MAX_NODES);
  assign is_root   = (parent_q == pcst_pkg::ParentRoot);
  assign par_idx   = parent_q[ParW-1:0];
  assign has_child = child_valid_q[par_idx];
  assign last_idx  = child_rd_q[IdxW-1:0];
  assign first_idx = child_rd_q[2*IdxW-1:IdxW];
  assign do_load   = cmd_i.finish && (kind_q == pcst_pkg::KindLoad) && !full;
  assign link      = do_load && in_range;

  // Sibling port: invalidate the new node at capture, chain it at finish.
  always_comb begin
    sib_we = 1'b0;
    sib_wa = cur_idx;
    sib_wd = '0;
    if (load_cap) begin
      sib_we = 1'b1;
    end else if (link && has_child) begin
      sib_we = 1'b1;
      sib_wa = last_idx;
      sib_wd = {1'b1, cur_idx};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      father_mem[cur_idx] <= {in_range, parent_q[5:0]};
    end
    if (cmd_i.capture) begin
      father_rd_q <= father_mem[node_rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sib_we) begin
      sib_mem[sib_wa] <= sib_wd;
    end
    if (cmd_i.capture) begin
      sib_rd_q <= sib_mem[node_rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (link) begin
      child_mem[par_idx] <= {(has_child ? first_idx : cur_idx), cur_idx};
    end
    if (cmd_i.capture) begin
      child_rd_q <= child_mem[child_rd_idx];
    end
  end

  always_comb begin
    count_d       = count_q;
    root_idx_d    = root_idx_q;
    root_valid_d  = root_valid_q;
    child_valid_d = child_valid_q;
    cur_ext       = 32'(cur_idx);
    if (cmd_i.finish && (kind_q == pcst_pkg::KindClear)) begin
      count_d       = '0;
      root_idx_d    = '0;
      root_valid_d  = 1'b0;
      child_valid_d = '0;
    end else if (do_load) begin
      count_d = count_q + CntW'(1);
      if (is_root) begin
        root_idx_d   = cur_ext[5:0];
        root_valid_d = 1'b1;
      end
      if (link) begin
        child_valid_d[par_idx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      root_idx_q    <= '0;
      root_valid_q  <= 1'b0;
      child_valid_q <= '0;
    end else begin
      count_q       <= count_d;
      root_idx_q    <= root_idx_d;
      root_valid_q  <= root_valid_d;
      child_valid_q <= child_valid_d;
    end
  end

  // --- result --------------------------------------------------------------
  assign k_ok      = (32'(node_q) < 32'(count_q));
  assign first_ext = 32'(first_idx);
  assign sib_ext   = 32'(sib_rd_q[IdxW-1:0]);
  assign cnt_ext   = 32'(count_d);

  always_comb begin
    status_d           = pcst_pkg::StOk;
    father_d           = '0;
    has_father_d       = 1'b0;
    first_child_d      = '0;
    has_first_child_d  = 1'b0;
    next_sibling_d     = '0;
    has_next_sibling_d = 1'b0;
    unique case (kind_q)
      pcst_pkg::KindClear: begin
        status_d = pcst_pkg::StOk;
      end
      pcst_pkg::KindLoad: begin
        status_d = full ? pcst_pkg::StFull : pcst_pkg::StOk;
      end
      pcst_pkg::KindQuery: begin
        if (!k_ok) begin
          status_d = pcst_pkg::StRange;
        end else begin
          if (father_rd_q[6]) begin
            father_d     = father_rd_q[5:0];
            has_father_d = 1'b1;
          end
          if (child_valid_q[node_q[ParW-1:0]]) begin
            first_child_d     = first_ext[5:0];
            has_first_child_d = 1'b1;
          end
          if (sib_rd_q[IdxW]) begin
            next_sibling_d     = sib_ext[5:0];
            has_next_sibling_d = 1'b1;
          end
        end
      end
      default: begin
        status_d = pcst_pkg::StOk;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q           <= status_d;
      father_q           <= father_d;
      has_father_q       <= has_father_d;
      first_child_q      <= first_child_d;
      has_first_child_q  <= has_first_child_d;
      next_sibling_q     <= next_sibling_d;
      has_next_sibling_q <= has_next_sibling_d;
      root_node_q        <= root_idx_d;
      has_root_q         <= root_valid_d;
      node_count_q       <= cnt_ext[6:0];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign father_o           = father_q;
  assign has_father_o       = has_father_q;
  assign first_child_o      = first_child_q;
  assign has_first_child_o  = has_first_child_q;
  assign next_sibling_o     = next_sibling_q;
  assign has_next_sibling_o = has_next_sibling_q;
  assign root_node_o        = root_node_q;
  assign has_root_o         = has_root_q;
  assign node_count_o       = node_count_q;

endmodule

`default_nettype wire

>>> hw/rtl/parent_to_child_sibling_table.sv
// Flow: a beat taken in idle loads the result register in the finish state,
//   which waits while the result register is full; no beat is taken there.
//   Child table: read the parent's last child at capture, write back at finish.
// An unused-kind beat is taken in idle and gives no result.
// Reset: counters, root and child valid bits clear at once; the node tables
//   are left unwritten and need no clearing pass, so a beat is taken right away.
// ----------------------------------------------------------------------------
// parent_to_child_sibling_table
// Builds a first-child / next-sibling table from parents given in node order,
// and answers queries on father, first child, next sibling and root.
// ----------------------------------------------------------------------------
`default_nettype none

module parent_to_child_sibling_table #(
  parameter int unsigned MAX_NODES = pcst_pkg::MaxNodesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcst_in_if.sink    in_i,
  pcst_out_if.source out_o
);

  pcst_pkg::cmd_t cmd;
  pcst_pkg::sts_t sts;

  // Sequencer: idle takes a beat, finish waits for a free result register.
  pcst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: node tables (father, sibling) sized to MAX_NODES, child table to
  // the smaller of MAX_NODES and the parents the port can name, and the result
  // register that decouples the output so a new beat is taken while one waits.
  pcst_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .kind_i             (in_i.kind),
    .parent_i           (in_i.parent),
    .node_i             (in_i.node),
    .out_ready_i        (out_o.ready),
    .out_valid_o        (out_o.valid),
    .status_o           (out_o.status),
    .father_o           (out_o.father),
    .has_father_o       (out_o.has_father),
    .first_child_o      (out_o.first_child),
    .has_first_child_o  (out_o.has_first_child),
    .next_sibling_o     (out_o.next_sibling),
    .has_next_sibling_o (out_o.has_next_sibling),
    .root_node_o        (out_o.root_node),
    .has_root_o         (out_o.has_root),
    .node_count_o       (out_o.node_count)
  );

  // A captured real beat finishes next cycle unless the result side stalls.
  a_capture_then_finish : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd.capture && !sts.nop |=> cmd.finish || sts.out_busy
  ) else $error("captured beat neither finished nor stalled");

  // Finishing loads the result register.
  a_finish_gives_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_o.valid
  ) else $error("finish did not present a result");

  // After a finish the block is back to taking beats.
  a_finish_returns_idle : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> in_i.ready && !cmd.finish
  ) else $error("block not idle after finish");

endmodule

`default_nettype wire

>>> tb/sv/tb_parent_to_child_sibling_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_parent_to_child_sibling_table
// Drives clear, load and query beats into the first-child / next-sibling table
// and checks every result beat against a cycle-free prediction of the tree.
// ----------------------------------------------------------------------------

module tb_parent_to_child_sibling_table;

  localparam int unsigned MaxNodes   = pcst_pkg::MaxNodesDef;
  localparam int unsigned ItemTarget = 1250;
  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned DrainCyc   = 8;
  // Receiver hold-off: starts after this many input beats, lasts this long.
  localparam int unsigned HoldAt     = 400;
  localparam int unsigned HoldCyc    = 200;
  // Stretch of input beats in which neither side idles.
  localparam int unsigned QuietLo    = 700;
  localparam int unsigned QuietHi    = 1000;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] parent;
    logic [5:0] node;
  } tree_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] father;
    logic       has_father;
    logic [5:0] first_child;
    logic       has_first_child;
    logic [5:0] next_sibling;
    logic       has_next_sibling;
    logic [5:0] root_node;
    logic       has_root;
    logic [6:0] node_count;
  } tree_res_t;

  logic clk_i;
  logic rst_ni;

  pcst_in_if  req_ch ();
  pcst_out_if res_ch ();

  parent_to_child_sibling_table DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch.sink),
    .out_o  (res_ch.source)
  );

  // Beats waiting to be driven, and results the tree should produce.
  tree_req_t pending_q[$];
  tree_res_t answers_q[$];

  int unsigned beats_in;
  int unsigned cycles;
  int unsigned errors;
  logic        hold_rx;

  // Predicted tree: one copy of every table the block keeps.
  int unsigned tr_count;
  logic [5:0]  tr_father   [MaxNodes];
  bit          tr_father_ok[MaxNodes];
  logic [5:0]  tr_first    [MaxNodes];
  bit          tr_first_ok [MaxNodes];
  logic [5:0]  tr_last     [MaxNodes];
  logic [5:0]  tr_sib      [MaxNodes];
  bit          tr_sib_ok   [MaxNodes];
  logic [5:0]  tr_root;
  bit          tr_root_ok;

  // Idle only outside the quiet stretch.
  function automatic bit idle_now();
    if (beats_in >= QuietLo && beats_in < QuietHi) return 1'b0;
    return $urandom_range(0, 99) < 10;
  endfunction

  task automatic tree_clear();
    tr_count   = 0;
    tr_root    = '0;
    tr_root_ok = 1'b0;
    for (int i = 0; i < MaxNodes; i++) begin
      tr_father_ok[i] = 1'b0;
      tr_first_ok[i]  = 1'b0;
      tr_sib_ok[i]    = 1'b0;
    end
  endtask

  // Apply one beat to the predicted tree and work out its result beat.
  task automatic tree_apply(input tree_req_t r, output bit has_res, output tree_res_t e);
    int unsigned n;
    int unsigned q;
    int unsigned k;
    e       = '0;
    has_res = (r.kind != pcst_pkg::KindUnused);
    if (!has_res) return;
    case (r.kind)
      pcst_pkg::KindClear: begin
        tree_clear();
      end
      pcst_pkg::KindLoad: begin
        if (tr_count >= MaxNodes) begin
          e.status = pcst_pkg::StFull;
        end else begin
          n = tr_count;
          tr_father_ok[n] = 1'b0;
          tr_sib_ok[n]    = 1'b0;
          if (r.parent == pcst_pkg::ParentRoot) begin
            tr_root    = n[5:0];
            tr_root_ok = 1'b1;
          end else if (!r.parent[6] && int'(r.parent[5:0]) < MaxNodes) begin
            // Append to the parent's child list, behind its last child.
            q = 32'(r.parent[5:0]);
            tr_father[n]    = q[5:0];
            tr_father_ok[n] = 1'b1;
            if (tr_first_ok[q]) begin
              tr_sib[tr_last[q]]    = n[5:0];
              tr_sib_ok[tr_last[q]] = 1'b1;
            end else begin
              tr_first[q]    = n[5:0];
              tr_first_ok[q] = 1'b1;
            end
            tr_last[q] = n[5:0];
          end
          tr_count = n + 1;
        end
      end
      default: begin
        k = 32'(r.node);
        if (k >= tr_count) begin
          e.status = pcst_pkg::StRange;
        end else begin
          if (tr_father_ok[k]) begin
            e.father     = tr_father[k];
            e.has_father = 1'b1;
          end
          if (tr_first_ok[k]) begin
            e.first_child     = tr_first[k];
            e.has_first_child = 1'b1;
          end
          if (tr_sib_ok[k]) begin
            e.next_sibling     = tr_sib[k];
            e.has_next_sibling = 1'b1;
          end
        end
      end
    endcase
    e.root_node  = tr_root_ok ? tr_root : '0;
    e.has_root   = tr_root_ok;
    e.node_count = tr_count[6:0];
  endtask

  task automatic check_field(input string name, input logic [6:0] want, input logic [6:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic queue_beat(input logic [1:0] kind, input logic [6:0] parent,
                            input logic [5:0] node);
    tree_req_t r;
    r.kind   = kind;
    r.parent = parent;
    r.node   = node;
    pending_q.insert(pending_q.size(), r);
  endtask

  // Parent for node n of a well-formed tree: mostly a lower index, sometimes
  // a root, a detached code, a forward or self index, or any code at all.
  function automatic logic [6:0] pick_parent(input int unsigned n);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70 && n > 0) return 7'($urandom_range(0, n - 1));
    if (roll < 78) return pcst_pkg::ParentRoot;
    if (roll < 85) return 7'($urandom_range(64, 126));
    if (roll < 95) return 7'($urandom_range(0, 63));
    return 7'($urandom);
  endfunction

  // Query target: mostly a loaded node, sometimes anything.
  function automatic logic [5:0] pick_node(input int unsigned loaded);
    if (loaded > 0 && $urandom_range(0, 99) < 80) return 6'($urandom_range(0, loaded - 1));
    return 6'($urandom);
  endfunction

  // Clock: 10 ns period.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Known values on every input from time zero; reset is held, then released.
  initial begin
    rst_ni        = 1'b0;
    hold_rx       = 1'b0;
    req_ch.valid  = 1'b0;
    req_ch.kind   = pcst_pkg::KindClear;
    req_ch.parent = '0;
    req_ch.node   = '0;
    res_ch.ready  = 1'b0;
    beats_in      = 0;
    cycles        = 0;
    errors        = 0;
    tree_clear();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Stimulus: directed beats first, then random trees with some noise.
  initial begin : stimulus
    int unsigned issued;
    int unsigned loads;
    int unsigned size;
    int unsigned nq;
    logic [1:0]  k;

    // Directed: empty query, root, siblings, self and forward parents,
    // detached codes at both ends, root replacement, out-of-range queries,
    // an unused kind, and a clear in the middle of a tree.
    queue_beat(pcst_pkg::KindClear, '0, '0);
    queue_beat(pcst_pkg::KindQuery, '0, 6'd0);
    queue_beat(pcst_pkg::KindLoad, pcst_pkg::ParentRoot, '0);
    queue_beat(pcst_pkg::KindLoad, 7'd0, '0);
    queue_beat(pcst_pkg::KindLoad, 7'd0, '0);
    queue_beat(pcst_pkg::KindLoad, 7'd1, '0);
    queue_beat(pcst_pkg::KindLoad, 7'd4, '0);
    queue_beat(pcst_pkg::KindLoad, 7'd63, '0);
    queue_beat(pcst_pkg::KindLoad, 7'h7E, '0);
    queue_beat(pcst_pkg::KindLoad, 7'h40, '0);
    queue_beat(pcst_pkg::KindLoad, pcst_pkg::ParentRoot, '0);
    queue_beat(pcst_pkg::KindLoad, 7'd0, '0);
    queue_beat(pcst_pkg::KindLoad, 7'd5, '0);
    queue_beat(pcst_pkg::KindQuery, '0, 6'd0);
    queue_beat(pcst_pkg::KindQuery, '0, 6'd1);
    queue_beat(pcst_pkg::KindQuery, '0, 6'd2);
    queue_beat(pcst_pkg::KindQuery, '0, 6'd4);
    queue_beat(pcst_pkg::KindQuery, '0, 6'd5);
    queue_beat(pcst_pkg::KindQuery, '0, 6'd8);
    queue_beat(pcst_pkg::KindQuery, '0, 6'd63);
    queue_beat(pcst_pkg::KindQuery, '0, 6'd11);
    queue_beat(pcst_pkg::KindUnused, 7'h3F, 6'h3F);
    queue_beat(pcst_pkg::KindClear, '0, '0);
    queue_beat(pcst_pkg::KindQuery, '0, 6'd0);
    queue_beat(pcst_pkg::KindLoad, 7'd63, '0);

    issued = 0;
    while (issued < ItemTarget) begin
      if ($urandom_range(0, 99) < 85) begin
        // Well-formed tree: clear, loads with scattered queries, then queries.
        queue_beat(pcst_pkg::KindClear, 7'($urandom), 6'($urandom));
        issued++;
        size  = ($urandom_range(0, 9) == 0) ? MaxNodes + $urandom_range(0, 4)
                                            : $urandom_range(1, 12);
        loads = 0;
        for (int unsigned i = 0; i < size; i++) begin
          queue_beat(pcst_pkg::KindLoad, pick_parent(loads), 6'($urandom));
          issued++;
          if (loads < MaxNodes) loads++;
          if ($urandom_range(0, 99) < 30) begin
            queue_beat(pcst_pkg::KindQuery, 7'($urandom), pick_node(loads));
            issued++;
          end
        end
        nq = (loads > 16 ? 16 : loads) / 2 + 2;
        for (int unsigned i = 0; i < nq; i++) begin
          queue_beat(pcst_pkg::KindQuery, 7'($urandom), pick_node(loads));
          issued++;
        end
      end else begin
        // Noise: any kind, any fields; unused kinds do not count.
        for (int unsigned i = 0; i < 4; i++) begin
          k = 2'($urandom);
          queue_beat(k, 7'($urandom), 6'($urandom));
          if (k != pcst_pkg::KindUnused) issued++;
        end
      end
    end

    @(posedge clk_i);
    while (rst_ni !== 1'b1 || pending_q.size() > 0 || req_ch.valid) @(posedge clk_i);
    while (answers_q.size() > 0) @(posedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);
    if (answers_q.size() > 0) begin
      $display("%0t: %0d results never arrived", $time, answers_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_parent_to_child_sibling_table: clean");
    end else begin
      $display("tb_parent_to_child_sibling_table: errors");
    end
    $finish;
  end

  // Driver: predict each accepted beat, then offer the next pending one or idle.
  always @(posedge clk_i) begin : drive
    tree_req_t cur;
    tree_req_t nxt;
    tree_res_t want;
    bit        has_res;
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        cur.kind   = req_ch.kind;
        cur.parent = req_ch.parent;
        cur.node   = req_ch.node;
        tree_apply(cur, has_res, want);
        if (has_res) answers_q.insert(answers_q.size(), want);
        beats_in <= beats_in + 1;
      end
      // Hold the beat while it is not taken; otherwise advance or idle.
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_q.size() > 0 && !idle_now()) begin
          nxt = pending_q.pop_front();
          req_ch.valid  <= 1'b1;
          req_ch.kind   <= nxt.kind;
          req_ch.parent <= nxt.parent;
          req_ch.node   <= nxt.node;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result beat with the oldest prediction.
  always @(posedge clk_i) begin : watch
    tree_res_t got;
    tree_res_t want;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got.status           = res_ch.status;
        got.father           = res_ch.father;
        got.has_father       = res_ch.has_father;
        got.first_child      = res_ch.first_child;
        got.has_first_child  = res_ch.has_first_child;
        got.next_sibling     = res_ch.next_sibling;
        got.has_next_sibling = res_ch.has_next_sibling;
        got.root_node        = res_ch.root_node;
        got.has_root         = res_ch.has_root;
        got.node_count       = res_ch.node_count;
        if (answers_q.size() == 0) begin
          $display("%0t: result beat with none expected, expected nothing, got %h",
                   $time, got);
          errors++;
        end else begin
          want = answers_q.pop_front();
          check_field("status", 7'(want.status), 7'(got.status));
          check_field("father", 7'(want.father), 7'(got.father));
          check_field("has_father", 7'(want.has_father), 7'(got.has_father));
          check_field("first_child", 7'(want.first_child), 7'(got.first_child));
          check_field("has_first_child", 7'(want.has_first_child), 7'(got.has_first_child));
          check_field("next_sibling", 7'(want.next_sibling), 7'(got.next_sibling));
          check_field("has_next_sibling", 7'(want.has_next_sibling),
                      7'(got.has_next_sibling));
          check_field("root_node", 7'(want.root_node), 7'(got.root_node));
          check_field("has_root", 7'(want.has_root), 7'(got.has_root));
          check_field("node_count", want.node_count, got.node_count);
        end
      end
      res_ch.ready <= !hold_rx && !idle_now();
    end
  end

  // Back-pressure: drop ready for a long stretch so the block fills and
  // stalls its input while the driver keeps offering beats.
  initial begin : hold_off
    wait (beats_in >= HoldAt);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HoldCyc) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb_parent_to_child_sibling_table: errors");
      $finish;
    end
  end

endmodule

>>> filelist.f
hw/rtl/pcst_pkg.sv
hw/rtl/pcst_if.sv
hw/rtl/pcst_ctrl.sv
hw/rtl/pcst_dp.sv
hw/rtl/parent_to_child_sibling_table.sv
tb/sv/tb_parent_to_child_sibling_table.sv
